// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds now, so b holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// a holds now, so b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next cycle check failed");

`endif

// ===== hw/rtl/ste_pkg.sv =====
// package: types, constants and codes of the sorted table engine
`default_nettype none
package ste_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int FUNC_W        = 4;
    localparam int KEYIN_W       = 32;
    localparam int POS_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int VALUE_W       = 32;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH_FRONT  = 4'd0,
        F_PUSH_BACK   = 4'd1,
        F_INSERT_AT   = 4'd2,
        F_SORTED_INS  = 4'd3,
        F_POP_FRONT   = 4'd4,
        F_POP_BACK    = 4'd5,
        F_REMOVE_KEY  = 4'd6,
        F_ERASE_AT    = 4'd7,
        F_SEARCH      = 4'd8,
        F_READ_AT     = 4'd9
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        AT_ZERO,
        AT_COUNT,
        AT_POS,
        AT_LO,
        AT_LAST
    } at_sel_t;

    typedef enum logic [1:0] {
        RD_MID,
        RD_AT,
        RD_PTR_DN,
        RD_PTR_UP
    } rd_sel_t;

    localparam logic REG_SIGNED_ORDER = 1'b0;

    typedef struct packed {
        logic    load;
        logic    srch_step;
        logic    upper;
        logic    at_ld;
        at_sel_t at_sel;
        logic    ptr_open;
        logic    ptr_close;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_open;
        logic    wr_close;
        logic    wr_key;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        status_t status;
        logic    set_found;
        logic    set_value;
        logic    set_index;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  empty;
        logic  pos_bad_ins;
        logic  pos_bad;
        logic  srch_go;
        logic  lo_in;
        logic  key_eq;
        logic  open_go;
        logic  close_go;
        logic  out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ste_req_if.sv =====
// interfaces: request and response word channels
`default_nettype none
interface ste_req_if;
    import ste_pkg::*;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [KEYIN_W-1:0] key_value;
    logic [POS_W-1:0]   position;
    modport source (output valid, func, key_value, position, input ready);
    modport sink (input valid, func, key_value, position, output ready);
endinterface

interface ste_rsp_if;
    import ste_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  value_out;
    logic [INDEX_W-1:0]  index_out;
    logic [COUNT_W-1:0]  count;
    modport source (output valid, status, found, value_out, index_out, count, input ready);
    modport sink (input valid, status, found, value_out, index_out, count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ste_ram.sv =====
// generic ram: one write port, one registered read port
`default_nettype none
module ste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ste_datapath.sv =====
// datapath: table memory, search bounds, shift pointer, count and result word
`default_nettype none
module ste_datapath #(
    parameter int CAPACITY  = ste_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ste_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          signed_order,
    input  wire ste_pkg::cmd_t                 cmd,
    output ste_pkg::sts_t                      sts,
    input  wire logic [ste_pkg::FUNC_W-1:0]    in_func,
    input  wire logic [ste_pkg::KEYIN_W-1:0]   in_key,
    input  wire logic [ste_pkg::POS_W-1:0]     in_pos,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ste_pkg::STATUS_W-1:0]       out_status,
    output logic                               out_found,
    output logic [ste_pkg::VALUE_W-1:0]        out_value,
    output logic [ste_pkg::INDEX_W-1:0]        out_index,
    output logic [ste_pkg::COUNT_W-1:0]        out_count
);
    import ste_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [KEY_WIDTH-1:0] SIGN = KEY_WIDTH'(1) << (KEY_WIDTH - 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    func_t                func_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        at_reg, at_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    status_t              r_status_reg;
    logic                 r_found_reg;
    logic [KEY_WIDTH-1:0] r_value_reg;
    logic [CW-1:0]        r_index_reg;
    logic                 o_valid_reg;
    status_t              o_status_reg;
    logic                 o_found_reg;
    logic [KEY_WIDTH-1:0] o_value_reg;
    logic [CW-1:0]        o_index_reg;
    logic [CW-1:0]        o_count_reg;

    logic [KEY_WIDTH-1:0] rdata;
    logic [KEY_WIDTH-1:0] ord_e, ord_k;
    logic [CW:0]          sum;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        ptr_dn;
    logic [CW:0]          ptr_up;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 wr_en;
    logic                 go_lo;

    assign sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid    = sum[CW:1];
    assign ptr_dn = ptr_reg - 1'b1;
    assign ptr_up = {1'b0, ptr_reg} + 1'b1;
    assign ord_e  = signed_order ? (rdata ^ SIGN) : rdata;
    assign ord_k  = signed_order ? (key_reg ^ SIGN) : key_reg;
    assign go_lo  = (ord_e < ord_k) || (cmd.upper && (ord_e == ord_k));

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_MID:    rd_addr = mid[AW-1:0];
            RD_AT:     rd_addr = at_reg[AW-1:0];
            RD_PTR_DN: rd_addr = ptr_dn[AW-1:0];
            RD_PTR_UP: rd_addr = ptr_up[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    assign wr_en   = cmd.wr_key || cmd.wr_open || cmd.wr_close;
    assign wr_addr = cmd.wr_key ? at_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_data = cmd.wr_key ? key_reg : rdata;

    ste_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rdata)
    );

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        at_next  = at_reg;
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            lo_next = '0;
            hi_next = cnt_reg;
        end
        if (cmd.srch_step)
        begin
            if (go_lo)
            begin
                lo_next = mid + 1'b1;
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.at_ld)
        begin
            unique case (cmd.at_sel)
                AT_ZERO:  at_next = '0;
                AT_COUNT: at_next = cnt_reg;
                AT_POS:   at_next = CW'(pos_reg);
                AT_LO:    at_next = lo_reg;
                AT_LAST:  at_next = cnt_reg - 1'b1;
                default:  at_next = '0;
            endcase
        end
        if (cmd.ptr_open)
        begin
            ptr_next = cnt_reg;
        end
        if (cmd.ptr_close)
        begin
            ptr_next = at_reg;
        end
        if (cmd.wr_open)
        begin
            ptr_next = ptr_dn;
        end
        if (cmd.wr_close)
        begin
            ptr_next = ptr_up[CW-1:0];
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.finish)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        at_reg  <= at_next;
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            func_reg     <= func_t'(in_func);
            key_reg      <= KEY_WIDTH'(in_key);
            pos_reg      <= in_pos;
            r_status_reg <= ST_OK;
            r_found_reg  <= 1'b0;
            r_value_reg  <= '0;
            r_index_reg  <= '0;
        end
        if (cmd.set_status)
        begin
            r_status_reg <= cmd.status;
        end
        if (cmd.set_found)
        begin
            r_found_reg <= 1'b1;
        end
        if (cmd.set_value)
        begin
            r_value_reg <= rdata;
        end
        if (cmd.set_index)
        begin
            r_index_reg <= at_reg;
        end
        if (cmd.finish)
        begin
            o_status_reg <= r_status_reg;
            o_found_reg  <= r_found_reg;
            o_value_reg  <= r_value_reg;
            o_index_reg  <= r_index_reg;
            o_count_reg  <= cnt_reg;
        end
    end

    always_comb
    begin
        sts.func        = func_reg;
        sts.full        = (cnt_reg == CAP_C);
        sts.empty       = (cnt_reg == '0);
        sts.pos_bad_ins = (CMPW'(pos_reg) > CMPW'(cnt_reg));
        sts.pos_bad     = (CMPW'(pos_reg) >= CMPW'(cnt_reg));
        sts.srch_go     = (lo_reg < hi_reg);
        sts.lo_in       = (lo_reg < cnt_reg);
        sts.key_eq      = (rdata == key_reg);
        sts.open_go     = (ptr_reg > at_reg);
        sts.close_go    = (ptr_up < {1'b0, cnt_reg});
        sts.out_free    = !o_valid_reg || out_ready;
    end

    assign out_valid  = o_valid_reg;
    assign out_status = o_status_reg;
    assign out_found  = o_found_reg;
    assign out_value  = VALUE_W'(o_value_reg);
    assign out_index  = INDEX_W'(o_index_reg);
    assign out_count  = COUNT_W'(o_count_reg);
endmodule
`default_nettype wire

// ===== hw/rtl/ste_ctrl.sv =====
// controller: sequences decode, binary search, shifts and result hand-off
`default_nettype none
module ste_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ste_pkg::sts_t sts,
    output ste_pkg::cmd_t      cmd
);
    import ste_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH,
        S_SRCH_CMP,
        S_FETCH,
        S_FETCH_WAIT,
        S_OPEN,
        S_OPEN_WR,
        S_CLOSE,
        S_CLOSE_WR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   is_insert;

    assign is_insert = (sts.func == F_SORTED_INS);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.func)
                    F_PUSH_FRONT, F_PUSH_BACK, F_INSERT_AT, F_SORTED_INS:
                    begin
                        priority if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                            state_next     = S_FINISH;
                        end
                        else if (sts.func == F_INSERT_AT && sts.pos_bad_ins)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                            state_next     = S_FINISH;
                        end
                        else if (sts.func == F_SORTED_INS)
                        begin
                            state_next = S_SRCH;
                        end
                        else
                        begin
                            cmd.at_ld    = 1'b1;
                            cmd.at_sel   = (sts.func == F_PUSH_FRONT) ? AT_ZERO :
                                           (sts.func == F_PUSH_BACK) ? AT_COUNT : AT_POS;
                            cmd.ptr_open = 1'b1;
                            state_next   = S_OPEN;
                        end
                    end
                    F_POP_FRONT, F_POP_BACK, F_REMOVE_KEY, F_SEARCH, F_ERASE_AT,
                    F_READ_AT:
                    begin
                        priority if (sts.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                            state_next     = S_FINISH;
                        end
                        else if (sts.func == F_REMOVE_KEY || sts.func == F_SEARCH)
                        begin
                            state_next = S_SRCH;
                        end
                        else if (sts.func == F_POP_FRONT || sts.func == F_POP_BACK)
                        begin
                            cmd.at_ld  = 1'b1;
                            cmd.at_sel = (sts.func == F_POP_FRONT) ? AT_ZERO : AT_LAST;
                            state_next = S_FETCH;
                        end
                        else if (sts.pos_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.at_ld  = 1'b1;
                            cmd.at_sel = AT_POS;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SRCH:
            begin
                priority if (sts.srch_go)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = S_SRCH_CMP;
                end
                else if (is_insert)
                begin
                    cmd.at_ld    = 1'b1;
                    cmd.at_sel   = AT_LO;
                    cmd.ptr_open = 1'b1;
                    state_next   = S_OPEN;
                end
                else if (sts.lo_in)
                begin
                    cmd.at_ld  = 1'b1;
                    cmd.at_sel = AT_LO;
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                cmd.upper     = is_insert;
                state_next    = S_SRCH;
            end
            S_FETCH:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_AT;
                cmd.ptr_close = 1'b1;
                state_next    = S_FETCH_WAIT;
            end
            S_FETCH_WAIT:
            begin
                unique case (sts.func)
                    F_REMOVE_KEY, F_SEARCH:
                    begin
                        if (sts.key_eq)
                        begin
                            cmd.set_found = 1'b1;
                            cmd.set_value = 1'b1;
                            cmd.set_index = 1'b1;
                            state_next    = (sts.func == F_REMOVE_KEY) ? S_CLOSE : S_FINISH;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    F_POP_FRONT, F_POP_BACK:
                    begin
                        cmd.set_value = 1'b1;
                        state_next    = S_CLOSE;
                    end
                    F_ERASE_AT:
                    begin
                        cmd.set_value = 1'b1;
                        cmd.set_index = 1'b1;
                        state_next    = S_CLOSE;
                    end
                    default:
                    begin
                        cmd.set_value = 1'b1;
                        cmd.set_index = 1'b1;
                        state_next    = S_FINISH;
                    end
                endcase
            end
            S_OPEN:
            begin
                if (sts.open_go)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_DN;
                    state_next = S_OPEN_WR;
                end
                else
                begin
                    cmd.wr_key    = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    cmd.set_index = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_OPEN_WR:
            begin
                cmd.wr_open = 1'b1;
                state_next  = S_OPEN;
            end
            S_CLOSE:
            begin
                if (sts.close_go)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_UP;
                    state_next = S_CLOSE_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_CLOSE_WR:
            begin
                cmd.wr_close = 1'b1;
                state_next   = S_CLOSE;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sorted_table_engine_unit.sv =====
// steps from accepted word to result: full, empty, bad position and unused codes finish directly;
//   a read fetches the entry; a push opens a slot by moving each entry above it up, a pop, erase or
//   removal moves each entry above it down; a key search first runs at most clog2(CAPACITY)+1 steps
// throughput: one word at a time; the next word is taken the cycle after the result enters
//   the output register, which waits while the previous result is still held there
// reset: fill count, controller and output valid clear at once; contents are not cleared
`default_nettype none
module sorted_table_engine_unit #(
    parameter int CAPACITY  = ste_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ste_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ste_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ste_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ste_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    ste_req_if.sink                           req,
    ste_rsp_if.source                         rsp
);
    import ste_pkg::*;

    logic signed_order_reg;
    cmd_t cmd;
    sts_t sts;
    logic reg_sel;

    assign reg_sel = (paddr[PADDR_W-1] == REG_SIGNED_ORDER);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_W'(signed_order_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_order_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            signed_order_reg <= pwdata[0];
        end
    end

    ste_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ste_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .signed_order (signed_order_reg),
        .cmd          (cmd),
        .sts          (sts),
        .in_func      (req.func),
        .in_key       (req.key_value),
        .in_pos       (req.position),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_status   (rsp.status),
        .out_found    (rsp.found),
        .out_value    (rsp.value_out),
        .out_index    (rsp.index_out),
        .out_count    (rsp.count)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/ste_checker.sv =====
// checker: port level properties of the sorted table engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ste_checker #(
    parameter int CAPACITY = ste_pkg::CAPACITY_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [ste_pkg::STATUS_W-1:0]   rsp_status,
    input wire logic                           rsp_found,
    input wire logic [ste_pkg::VALUE_W-1:0]    rsp_value,
    input wire logic [ste_pkg::INDEX_W-1:0]    rsp_index,
    input wire logic [ste_pkg::COUNT_W-1:0]    rsp_count
);
    import ste_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_value) && $stable(rsp_count))
    `ASSERT_IMPLY(a_full_count, clk, rst_n, rsp_valid && rsp_status == ST_FULL, rsp_count == CAP_C)
    `ASSERT_IMPLY(a_empty_clean, clk, rst_n, rsp_valid && rsp_status == ST_EMPTY, rsp_count == '0 && !rsp_found && rsp_value == '0 && rsp_index == '0)
    `ASSERT_IMPLY(a_found_ok, clk, rst_n, rsp_valid && rsp_found, rsp_status == ST_OK)
endmodule

bind sorted_table_engine_unit ste_checker #(
    .CAPACITY (CAPACITY)
) u_ste_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_found  (rsp.found),
    .rsp_value  (rsp.value_out),
    .rsp_index  (rsp.index_out),
    .rsp_count  (rsp.count)
);
`default_nettype wire

// ===== tb/sorted_table_engine_unit_scb.sv =====
// scoreboard: table predictor and queue of expected result words
`timescale 1ns / 1ps
package sorted_table_scb_pkg;
    import ste_pkg::*;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [31:0] value_out;
        logic [5:0]  index_out;
        logic [6:0]  count;
    } table_result_t;

    class table_scoreboard;
        logic [31:0]   keys[64];
        int            fill;
        logic          signed_order;
        table_result_t pending[$];
        int            errors;

        function new();
            fill = 0;
            signed_order = 0;
            errors = 0;
            foreach (keys[i]) keys[i] = '0;
        endfunction

        function logic [31:0] order_of(logic [31:0] k);
            return signed_order ? (k ^ 32'h8000_0000) : k;
        endfunction

        function int bound(logic [31:0] k, bit upper);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = fill;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (order_of(keys[mid]) < order_of(k)
                    || (upper && keys[mid] == k))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void open_at(int at, logic [31:0] k);
            for (int i = fill; i > at; i--) keys[i] = keys[i-1];
            keys[at] = k;
            fill++;
        endfunction

        function void close_at(int at);
            for (int i = at; i + 1 < fill; i++) keys[i] = keys[i+1];
            fill--;
        endfunction

        function void note_request(logic [3:0] f, logic [31:0] k, logic [5:0] p);
            table_result_t r;
            int at;
            r = '0;
            r.status = ST_OK;
            case (f)
                F_PUSH_FRONT, F_PUSH_BACK, F_INSERT_AT, F_SORTED_INS:
                begin
                    if (fill >= 64) r.status = ST_FULL;
                    else if (f == F_INSERT_AT && p > fill) r.status = ST_BADPOS;
                    else
                    begin
                        if (f == F_PUSH_FRONT) at = 0;
                        else if (f == F_PUSH_BACK) at = fill;
                        else if (f == F_INSERT_AT) at = p;
                        else at = bound(k, 1);
                        open_at(at, k);
                        r.index_out = at;
                    end
                end
                F_POP_FRONT, F_POP_BACK:
                begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else
                    begin
                        at = (f == F_POP_FRONT) ? 0 : fill - 1;
                        r.value_out = keys[at];
                        close_at(at);
                    end
                end
                F_REMOVE_KEY, F_SEARCH:
                begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else
                    begin
                        at = bound(k, 0);
                        if (at < fill && keys[at] == k)
                        begin
                            r.found = 1;
                            r.value_out = k;
                            r.index_out = at;
                            if (f == F_REMOVE_KEY) close_at(at);
                        end
                    end
                end
                F_ERASE_AT, F_READ_AT:
                begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else if (p >= fill) r.status = ST_BADPOS;
                    else
                    begin
                        r.value_out = keys[p];
                        r.index_out = p;
                        if (f == F_ERASE_AT) close_at(p);
                    end
                end
                default: ;
            endcase
            r.count = fill;
            pending.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result word");
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status mismatch");
            if (got.found !== want.found) report("found mismatch");
            if (got.value_out !== want.value_out) report("value_out mismatch");
            if (got.index_out !== want.index_out) report("index_out mismatch");
            if (got.count !== want.count) report("count mismatch");
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
        endfunction
    endclass
endpackage

// ===== tb/sorted_table_engine_unit_tb.sv =====
// testbench top: stimulus, handshakes, register writes and end of run
`timescale 1ns / 1ps
module sorted_table_engine_unit_tb;
    import ste_pkg::*;
    import sorted_table_scb_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    ste_req_if req ();
    ste_rsp_if rsp ();

    sorted_table_engine_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req.sink), .rsp(rsp.source)
    );

    table_scoreboard scb;
    int idle_cycles = 0;
    int long_hold = 0;

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.func = '0;
        req.key_value = '0;
        req.position = '0;
        rsp.ready = 0;
    end

    // sample words at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                scb.note_request(req.func, req.key_value, req.position);
            if (rsp.valid && rsp.ready)
                scb.check_result({rsp.status, rsp.found, rsp.value_out,
                                  rsp.index_out, rsp.count});
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles > 5000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                rsp.ready <= 0;
                long_hold--;
            end
            else
            begin
                mode = (($time / 4000) % 3);
                if (mode == 0) rsp.ready <= 1;
                else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
                else rsp.ready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    task automatic cfg_write(logic [PADDR_W-1:0] a, logic [31:0] d);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= a;
        pwdata <= d;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_word(logic [3:0] f, logic [31:0] k, logic [5:0] p);
        req.valid <= 1;
        req.func <= f;
        req.key_value <= k;
        req.position <= p;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    task automatic gap();
        req.valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (scb.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_order(logic s);
        drain();
        cfg_write(REG_SIGNED_ORDER * 4, {31'b0, s});
        scb.signed_order = s;
    endtask

    function automatic logic [31:0] rand_key();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0) return 32'h0;
        if (c == 1) return 32'hFFFF_FFFF;
        if (c == 2) return 32'h8000_0000;
        if (c == 3) return 32'h7FFF_FFFF;
        if (c < 6) return $urandom_range(0, 15) ^ ({$urandom_range(0, 1), 31'b0});
        return $urandom;
    endfunction

    task automatic random_phase(int n, bit sorted_only);
        int burst;
        logic [3:0] f;
        logic [5:0] p;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                gap();
                burst = $urandom_range(1, 20);
            end
            burst--;
            if (sorted_only)
            begin
                case ($urandom_range(0, 4))
                    0, 1: f = F_SORTED_INS;
                    2: f = F_REMOVE_KEY;
                    3: f = F_SEARCH;
                    default: f = $urandom_range(0, 15);
                endcase
            end
            else
                f = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 15)
                                                  : $urandom_range(0, 9);
            if (scb.fill > 55 && $urandom_range(0, 1)) f = F_POP_BACK;
            p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, scb.fill);
            send_word(f, rand_key(), p);
        end
    endtask

    initial
    begin
        scb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed part: empty table, extremes, full table
        send_word(F_POP_FRONT, 0, 0);
        send_word(F_POP_BACK, 0, 0);
        send_word(F_SEARCH, 32'h5, 0);
        send_word(F_REMOVE_KEY, 32'h5, 0);
        send_word(F_ERASE_AT, 0, 0);
        send_word(F_READ_AT, 0, 63);
        send_word(F_INSERT_AT, 32'h1, 6'd1);
        send_word(F_PUSH_BACK, 32'hFFFF_FFFF, 0);
        send_word(F_PUSH_FRONT, 32'h0, 0);
        send_word(F_SORTED_INS, 32'h8000_0000, 0);
        send_word(F_SORTED_INS, 32'h8000_0000, 0);
        send_word(F_INSERT_AT, 32'h7FFF_FFFF, 6'd5);
        send_word(F_INSERT_AT, 32'h1234_5678, 6'd6);
        send_word(F_READ_AT, 0, 6'd5);
        send_word(F_READ_AT, 0, 6'd63);
        send_word(F_ERASE_AT, 0, 6'd1);
        send_word(F_SEARCH, 32'h8000_0000, 0);
        send_word(F_REMOVE_KEY, 32'h8000_0000, 0);
        send_word(4'd15, 32'hFFFF_FFFF, 6'd63);
        for (int i = 0; i < 64; i++) send_word(F_PUSH_BACK, $urandom, $urandom);
        send_word(F_PUSH_FRONT, 1, 0);
        send_word(F_SORTED_INS, 1, 0);
        send_word(F_INSERT_AT, 1, 0);
        for (int i = 0; i < 64; i++) send_word(F_POP_FRONT, 0, 0);
        // long receiver hold-off while the sender keeps offering
        long_hold = 400;
        random_phase(250, 0);
        drain();
        set_order(1);
        random_phase(350, 1);
        for (int i = 0; i < 70; i++) send_word(F_POP_BACK, 0, 0);
        set_order(0);
        random_phase(330, 1);
        set_order(1);
        random_phase(300, 0);
        drain();
        if (scb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ste_pkg.sv
hw/rtl/ste_req_if.sv
hw/rtl/ste_ram.sv
hw/rtl/ste_datapath.sv
hw/rtl/ste_ctrl.sv
hw/rtl/sorted_table_engine_unit.sv
hw/rtl/ste_checker.sv
tb/sorted_table_engine_unit_scb.sv
tb/sorted_table_engine_unit_tb.sv
